@@ rtl/lpc_pkg.sv @@
// Package for the lidar point colorizer: image geometry, register indexes and shared types.
// No dependencies.
package lpc_pkg;
  localparam int ImageWidth  = 640;
  localparam int ImageHeight = 480;
  localparam int ColW  = $clog2(ImageWidth);
  localparam int RowW  = $clog2(ImageHeight);
  localparam int AddrW = $clog2(ImageWidth * ImageHeight);

  localparam logic [2:0] REG_ROW0_AB = 3'd0;
  localparam logic [2:0] REG_ROW0_CD = 3'd1;
  localparam logic [2:0] REG_ROW1_AB = 3'd2;
  localparam logic [2:0] REG_ROW1_CD = 3'd3;
  localparam logic [2:0] REG_ROW2_AB = 3'd4;
  localparam logic [2:0] REG_ROW2_CD = 3'd5;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  // Quotient stages of the shared divider: one per magnitude bit checked.
  localparam int QuotW = 13;

  // Pixel-write delay line depth: the two projection stages plus the QuotW + 2
  // division stages that lie between an accepted word and its frame lookup.
  localparam int WrDelay = QuotW + 4;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         intensity;
  } point_t;
endpackage

@@ rtl/lpc_project.sv @@
// Projection stages: nine 32x32 products, then per-row 64-bit sums.
// Depends on lpc_pkg.
module lpc_project import lpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  point_t             in_pt,
  input  logic [63:0]        regs [6],
  output logic               out_valid,
  output point_t             out_pt,
  output logic signed [63:0] comp [3]
);
  logic               v1, v2;
  point_t             pt1;
  logic signed [63:0] prod [9];
  logic signed [31:0] off [3];

  function automatic logic signed [31:0] coef(input logic [63:0] r, input logic hi);
    coef = hi ? r[63:32] : r[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
    for (int r = 0; r < 3; r++) begin
      prod[r*3+0] <= coef(regs[r*2], 1'b1) * in_pt.x;
      prod[r*3+1] <= coef(regs[r*2], 1'b0) * in_pt.y;
      prod[r*3+2] <= coef(regs[r*2+1], 1'b1) * in_pt.z;
      off[r]      <= coef(regs[r*2+1], 1'b0);
    end
    pt1 <= in_pt;
    for (int r = 0; r < 3; r++) begin
      comp[r] <= prod[r*3] + prod[r*3+1] + prod[r*3+2]
                 + {{16{off[r][31]}}, off[r], 16'd0};
    end
    out_pt <= pt1;
  end
  assign out_valid = v2;
endmodule

@@ rtl/lpc_divide.sv @@
// Pipelined restoring division of two 64-bit magnitudes by one divisor, QuotW quotient bits.
// Quotients at or above 2^QuotW reject the point, so only the low bits are developed.
// Depends on lpc_pkg.
module lpc_divide import lpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  point_t             in_pt,
  input  logic signed [63:0] comp [3],
  output logic               out_valid,
  output point_t             out_pt,
  output logic               keep,
  output logic [ColW-1:0]    col,
  output logic [RowW-1:0]    row
);
  // Stage 0: magnitudes, sign compares, and the nonzero-divisor and positive-x check.
  logic               v0;
  point_t             pt0;
  logic [63:0]        na0, nb0, da0;
  logic               ok0, sa0, sb0;

  logic [63:0] c0a, c1a, c2a;
  always_comb begin
    c0a = comp[0][63] ? -comp[0] : comp[0];
    c1a = comp[1][63] ? -comp[1] : comp[1];
    c2a = comp[2][63] ? -comp[2] : comp[2];
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= in_valid;
    pt0 <= in_pt;
    na0 <= c0a;
    nb0 <= c1a;
    da0 <= c2a;
    sa0 <= comp[0][63] != comp[2][63];
    sb0 <= comp[1][63] != comp[2][63];
    ok0 <= (comp[2] != 64'sd0) && (in_pt.x > 32'sd0);
  end

  // Division stages: step s develops quotient bit QuotW-1-s.
  logic               vs  [QuotW+1];
  point_t             pts [QuotW+1];
  logic [63:0]        ra  [QuotW+1];
  logic [63:0]        rb  [QuotW+1];
  logic [63:0]        dd  [QuotW+1];
  logic [QuotW-1:0]   qa  [QuotW+1];
  logic [QuotW-1:0]   qb  [QuotW+1];
  logic               big_a [QuotW+1];
  logic               big_b [QuotW+1];
  logic               oks [QuotW+1];
  logic               sas [QuotW+1];
  logic               sbs [QuotW+1];

  always_comb begin
    vs[0] = v0; pts[0] = pt0; ra[0] = na0; rb[0] = nb0; dd[0] = da0;
    qa[0] = '0; qb[0] = '0; big_a[0] = 1'b0; big_b[0] = 1'b0;
    oks[0] = ok0; sas[0] = sa0; sbs[0] = sb0;
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_step
    localparam int Sh = QuotW - 1 - s;
    logic [64+QuotW-1:0] dsh;
    logic                hi_a, hi_b;
    logic                ge_a, ge_b;
    always_comb begin
      dsh  = {{QuotW{1'b0}}, dd[s]} << Sh;
      ge_a = {{QuotW{1'b0}}, ra[s]} >= dsh;
      ge_b = {{QuotW{1'b0}}, rb[s]} >= dsh;
      // Remainder at or above d*2^QuotW means quotient too large.
      hi_a = (s == 0) && ({{QuotW{1'b0}}, ra[s]} >= (dsh << 1));
      hi_b = (s == 0) && ({{QuotW{1'b0}}, rb[s]} >= (dsh << 1));
    end
    always_ff @(posedge clk) begin
      if (rst) vs[s+1] <= 1'b0;
      else     vs[s+1] <= vs[s];
      pts[s+1] <= pts[s];
      dd[s+1]  <= dd[s];
      oks[s+1] <= oks[s];
      sas[s+1] <= sas[s];
      sbs[s+1] <= sbs[s];
      big_a[s+1] <= big_a[s] | hi_a;
      big_b[s+1] <= big_b[s] | hi_b;
      ra[s+1] <= ge_a ? ra[s] - dsh[63:0] : ra[s];
      rb[s+1] <= ge_b ? rb[s] - dsh[63:0] : rb[s];
      qa[s+1] <= qa[s] | (QuotW'(ge_a) << Sh);
      qb[s+1] <= qb[s] | (QuotW'(ge_b) << Sh);
    end
  end

  // Final check stage.
  logic ka, kb;
  always_comb begin
    ka = !big_a[QuotW] && ((qa[QuotW] == '0) ||
         (!sas[QuotW] && (qa[QuotW] < QuotW'(ImageWidth))));
    kb = !big_b[QuotW] && ((qb[QuotW] == '0) ||
         (!sbs[QuotW] && (qb[QuotW] < QuotW'(ImageHeight))));
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vs[QuotW];
    out_pt <= pts[QuotW];
    keep   <= oks[QuotW] && ka && kb;
    col    <= qa[QuotW][ColW-1:0];
    row    <= qb[QuotW][RowW-1:0];
  end
endmodule

@@ rtl/lpc_frame.sv @@
// Frame store and output stage: delayed pixel writes, color lookup, result register.
// Depends on lpc_pkg.
module lpc_frame import lpc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [RowW-1:0] wr_row,
  input  logic [ColW-1:0] wr_col,
  input  logic [23:0]     wr_data,
  input  logic            rd_en,
  input  point_t          rd_pt,
  input  logic [RowW-1:0] rd_row,
  input  logic [ColW-1:0] rd_col,
  output logic            out_valid,
  output point_t          out_pt,
  output logic [23:0]     out_color
);
  logic [23:0] mem [ImageWidth*ImageHeight];
  logic [AddrW-1:0] wa, ra;

  // Write delay line: a pixel word lands in the store in step with the point
  // words around it, so a lookup sees exactly the pixels accepted before it.
  logic             wq_en   [WrDelay];
  logic [AddrW-1:0] wq_addr [WrDelay];
  logic [23:0]      wq_data [WrDelay];

  always_comb begin
    wa = AddrW'(wr_row) * AddrW'(ImageWidth) + AddrW'(wr_col);
    ra = AddrW'(rd_row) * AddrW'(ImageWidth) + AddrW'(rd_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WrDelay; i++) wq_en[i] <= 1'b0;
    end else begin
      wq_en[0] <= wr_en;
      for (int i = 1; i < WrDelay; i++) wq_en[i] <= wq_en[i-1];
    end
    wq_addr[0] <= wa;
    wq_data[0] <= wr_data;
    for (int i = 1; i < WrDelay; i++) begin
      wq_addr[i] <= wq_addr[i-1];
      wq_data[i] <= wq_data[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (wq_en[WrDelay-1]) mem[wq_addr[WrDelay-1]] <= wq_data[WrDelay-1];
    out_color <= mem[ra];
    out_pt    <= rd_pt;
    if (rst) out_valid <= 1'b0;
    else     out_valid <= rd_en;
  end
endmodule

@@ rtl/lidar_point_colorizer_unit.sv @@
// Lidar point colorizer top level: projection, division, frame store.
// A kept point passes through 2 projection stages, QuotW + 2 division stages
// and 1 lookup stage before it shows on the result ports.
// Throughput: one word per cycle; busy is never raised, the pipeline runs freely.
// The receiver cannot stall; each result word is held for one cycle only.
// Reset (rst, synchronous) clears the config registers and valid bits; the frame store is not cleared.
// Depends on lpc_pkg, lpc_project, lpc_divide, lpc_frame.
module lidar_point_colorizer_unit import lpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [8:0]         pixel_row,
  input  logic [9:0]         pixel_col,
  input  logic [7:0]         pixel_red,
  input  logic [7:0]         pixel_green,
  input  logic [7:0]         pixel_blue,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [7:0]         point_intensity,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] kept_x,
  output logic signed [31:0] kept_y,
  output logic signed [31:0] kept_z,
  output logic [7:0]         kept_intensity,
  output logic [7:0]         color_red,
  output logic [7:0]         color_green,
  output logic [7:0]         color_blue
);
  logic [63:0] regs [6];
  point_t      pt_in, pt_p, pt_d, pt_f;
  logic        v_p, v_d, keep;
  logic signed [63:0] comp [3];
  logic [ColW-1:0] col;
  logic [RowW-1:0] row;
  logic [23:0]     color;
  logic            pix_wr;

  // Never hold off input words.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) regs[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW0_AB: regs[0] <= cfg_data;
        REG_ROW0_CD: regs[1] <= cfg_data;
        REG_ROW1_AB: regs[2] <= cfg_data;
        REG_ROW1_CD: regs[3] <= cfg_data;
        REG_ROW2_AB: regs[4] <= cfg_data;
        REG_ROW2_CD: regs[5] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign pt_in = '{x: point_x, y: point_y, z: point_z, intensity: point_intensity};

  // Pixel writes travel a delay line in the frame stage and land in the store
  // in word order with the point lookups; out-of-image writes are dropped.
  assign pix_wr = start && (req_type == REQ_PIXEL) &&
                  (pixel_row < 9'(ImageHeight)) && (pixel_col < 10'(ImageWidth));

  lpc_project u_project (
    .clk(clk), .rst(rst),
    .in_valid(start && (req_type == REQ_POINT)),
    .in_pt(pt_in), .regs(regs),
    .out_valid(v_p), .out_pt(pt_p), .comp(comp)
  );

  lpc_divide u_divide (
    .clk(clk), .rst(rst),
    .in_valid(v_p), .in_pt(pt_p), .comp(comp),
    .out_valid(v_d), .out_pt(pt_d), .keep(keep), .col(col), .row(row)
  );

  lpc_frame u_frame (
    .clk(clk), .rst(rst),
    .wr_en(pix_wr), .wr_row(RowW'(pixel_row)), .wr_col(ColW'(pixel_col)),
    .wr_data({pixel_red, pixel_green, pixel_blue}),
    .rd_en(v_d && keep), .rd_pt(pt_d), .rd_row(row), .rd_col(col),
    .out_valid(done), .out_pt(pt_f), .out_color(color)
  );

  assign kept_x         = pt_f.x;
  assign kept_y         = pt_f.y;
  assign kept_z         = pt_f.z;
  assign kept_intensity = pt_f.intensity;
  assign color_red      = color[23:16];
  assign color_green    = color[15:8];
  assign color_blue     = color[7:0];
endmodule

@@ rtl/lpc_checker.sv @@
// Port-level checks for the lidar point colorizer, bound to the top level.
// Depends on lidar_point_colorizer_unit ports only.
module lpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               req_type,
  input logic               done,
  input logic signed [31:0] kept_x
);
  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");
  a_pixel_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req_type) |-> ##18 !done)
    else $error("pixel word produced a result");
  a_kept_positive: assert property (@(posedge clk) disable iff (rst)
    done |-> (kept_x > 32'sd0)) else $error("kept point with x not above zero");
endmodule

bind lidar_point_colorizer_unit lpc_checker u_lpc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
  .done(done), .kept_x(kept_x)
);

@@ sim/lidar_point_colorizer_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for lidar_point_colorizer_unit: drives pixel and point words, predicts kept points.
// Depends on lpc_pkg and the lidar_point_colorizer_unit RTL.
module lidar_point_colorizer_unit_tb;
  import lpc_pkg::*;

  localparam int NumPix     = ImageWidth * ImageHeight;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 40;   // well beyond the pipeline length

  typedef struct packed {
    logic        req;
    logic [8:0]  row;
    logic [9:0]  col;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  inten;
  } word_t;

  typedef struct packed {
    point_t      pt;
    logic [23:0] rgb;
  } colored_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic done;
  logic signed [31:0] kept_x, kept_y, kept_z;
  logic [7:0] kept_intensity, color_red, color_green, color_blue;

  word_t cur_word = '0;

  lidar_point_colorizer_unit dut (
    .clk, .rst, .start, .busy,
    .req_type       (cur_word.req),
    .pixel_row      (cur_word.row),
    .pixel_col      (cur_word.col),
    .pixel_red      (cur_word.red),
    .pixel_green    (cur_word.green),
    .pixel_blue     (cur_word.blue),
    .point_x        (cur_word.x),
    .point_y        (cur_word.y),
    .point_z        (cur_word.z),
    .point_intensity(cur_word.inten),
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .kept_x, .kept_y, .kept_z, .kept_intensity,
    .color_red, .color_green, .color_blue
  );

  always #10 clk = ~clk;

  // Words waiting to be sent, kept points not yet seen on the outputs.
  word_t       pending_words[$];
  colored_pt_t kept_points[$];

  // Predictor copy of the matrix and frame; generator copy used to avoid unwritten reads.
  logic [5:0][63:0] proj_matrix = '0;
  logic [5:0][63:0] gen_matrix  = '0;
  logic [23:0] frame_mem [NumPix];
  bit          gen_written [NumPix];

  int  idle_pct = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  taken = 1'b0;

  // One projected component: sum of exact Q32.32 products, wrapping in 64 bits.
  function automatic logic [63:0] proj_row(logic [5:0][63:0] m, int r,
                                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic signed [63:0] a, b, c, d, xe, ye, ze;
    a  = $signed(m[2*r][63:32]);
    b  = $signed(m[2*r][31:0]);
    c  = $signed(m[2*r+1][63:32]);
    d  = $signed(m[2*r+1][31:0]);
    xe = $signed(x);
    ye = $signed(y);
    ze = $signed(z);
    return a * xe + b * ye + c * ze + (d <<< 16);
  endfunction

  // Truncated quotient tested against 0..lim-1; a zero quotient from below counts as 0.
  function automatic bit coord_ok(logic [63:0] num, logic [63:0] den, int lim,
                                  output int unsigned q);
    logic [63:0] na, da, mag;
    na  = num[63] ? (~num + 64'd1) : num;
    da  = den[63] ? (~den + 64'd1) : den;
    mag = na / da;
    q   = mag[31:0];
    if (mag == 0) return 1'b1;
    if (num[63] != den[63]) return 1'b0;
    return mag < lim;
  endfunction

  // Decide whether a point is kept; addr is its frame entry.
  function automatic bit point_kept(logic [5:0][63:0] m, word_t w, output int unsigned addr);
    logic [63:0] c0, c1, c2;
    int unsigned col, row;
    addr = 0;
    c0 = proj_row(m, 0, w.x, w.y, w.z);
    c1 = proj_row(m, 1, w.x, w.y, w.z);
    c2 = proj_row(m, 2, w.x, w.y, w.z);
    if (c2 == 0) return 1'b0;
    if (!coord_ok(c0, c2, ImageWidth, col)) return 1'b0;
    if (!coord_ok(c1, c2, ImageHeight, row)) return 1'b0;
    if ($signed(w.x) <= 0) return 1'b0;
    addr = row * ImageWidth + col;
    return 1'b1;
  endfunction

  // Queue a word; make sure a kept point never looks up a pixel not yet written.
  task automatic queue_word(word_t w);
    int unsigned addr;
    word_t pw;
    if (w.req == REQ_POINT && point_kept(gen_matrix, w, addr) && !gen_written[addr]) begin
      pw       = w;
      pw.req   = REQ_PIXEL;
      pw.row   = 9'(addr / ImageWidth);
      pw.col   = 10'(addr % ImageWidth);
      pw.red   = 8'($urandom);
      pw.green = 8'($urandom);
      pw.blue  = 8'($urandom);
      gen_written[addr] = 1'b1;
      pending_words = {pending_words, pw};
    end
    if (w.req == REQ_PIXEL && w.row < ImageHeight && w.col < ImageWidth)
      gen_written[w.row * ImageWidth + w.col] = 1'b1;
    pending_words = {pending_words, w};
  endtask

  function automatic word_t rand_word();
    logic [159:0] raw;
    word_t w;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w   = raw[$bits(word_t)-1:0];
    return w;
  endfunction

  function automatic word_t pixel_word(int row, int col);
    word_t w;
    w     = rand_word();
    w.req = REQ_PIXEL;
    w.row = 9'(row);
    w.col = 10'(col);
    return w;
  endfunction

  function automatic word_t point_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    word_t w;
    w     = rand_word();
    w.req = REQ_POINT;
    w.x   = x;
    w.y   = y;
    w.z   = z;
    return w;
  endfunction

  // Random word: mostly points in front of the sensor, some pixels, some noise; wide makes every point noise.
  function automatic word_t stim_word(bit wide);
    int sel;
    word_t w;
    sel = $urandom_range(99);
    if (sel < 25) begin
      w = pixel_word($urandom_range(511), $urandom_range(1023));
      if (sel < 20) begin
        w.row = 9'($urandom_range(ImageHeight - 1));
        w.col = 10'($urandom_range(ImageWidth - 1));
      end
    end else if (sel < 35 || wide) begin
      w = rand_word();
      w.req = REQ_POINT;
    end else if (sel < 40) begin
      w = point_word(-$urandom_range(3 * 65536), $urandom, $urandom);
    end else begin
      w = point_word($urandom_range(65536 / 4, 20 * 65536),
                     $urandom_range(6 * 65536) - 3 * 65536,
                     $urandom_range(5 * 65536) - 5 * 65536 / 2);
    end
    return w;
  endfunction

  // Load the matrix through the config channel; call only while the block is idle.
  task automatic load_matrix(logic [5:0][63:0] m);
    for (int i = REG_ROW0_AB; i <= REG_ROW2_CD; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= m[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_matrix = m;
  endtask

  // Wait for all words sent and all kept points seen, then let the pipeline drain.
  task automatic drain();
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (kept_points.size() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Pinhole camera looking down +x: col = 320 + f*y/x, row = 240 + f*z/x.
  function automatic logic [5:0][63:0] pinhole(int f);
    logic [5:0][63:0] m;
    m[REG_ROW0_AB] = {32'(320 << 16), 32'(f << 16)};
    m[REG_ROW0_CD] = {32'd0, 32'd0};
    m[REG_ROW1_AB] = {32'(240 << 16), 32'd0};
    m[REG_ROW1_CD] = {32'(f << 16), 32'd0};
    m[REG_ROW2_AB] = {32'(1 << 16), 32'd0};
    m[REG_ROW2_CD] = {32'd0, 32'd0};
    return m;
  endfunction

  // Accept side: predict on every accepted word, record config writes.
  always @(posedge clk) begin
    int unsigned addr;
    colored_pt_t cp;
    taken = !rst && start && !busy;
    if (!rst && cfg_valid && cfg_ready) proj_matrix[cfg_index] <= cfg_data;
    if (taken) begin
      if (cur_word.req == REQ_PIXEL) begin
        if (cur_word.row < ImageHeight && cur_word.col < ImageWidth)
          frame_mem[cur_word.row * ImageWidth + cur_word.col] =
            {cur_word.red, cur_word.green, cur_word.blue};
      end else if (point_kept(proj_matrix, cur_word, addr)) begin
        cp.pt  = {cur_word.x, cur_word.y, cur_word.z, cur_word.inten};
        cp.rgb = frame_mem[addr];
        kept_points = {kept_points, cp};
      end
    end
  end

  // Driver: advance to the next word after a handshake, or idle at random.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_word <= pending_words.pop_front();
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest kept point.
  always @(posedge clk) begin
    colored_pt_t exp_cp, got;
    if (!rst && done) begin
      got.pt  = {kept_x, kept_y, kept_z, kept_intensity};
      got.rgb = {color_red, color_green, color_blue};
      if (kept_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %h", got);
      end else begin
        exp_cp = kept_points.pop_front();
        if (got !== exp_cp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h i=%h rgb=%h  got x=%h y=%h z=%h i=%h rgb=%h",
                     exp_cp.pt.x, exp_cp.pt.y, exp_cp.pt.z, exp_cp.pt.intensity, exp_cp.rgb,
                     got.pt.x, got.pt.y, got.pt.z, got.pt.intensity, got.rgb);
        end
      end
    end
  end

  // Cycle limit: end a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [5:0][63:0] m;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset matrix: every depth is zero, so every point is dropped.
    queue_word(point_word(32'h0001_0000, 32'h0, 32'h0));
    queue_word(point_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    for (int i = 0; i < 40; i++) queue_word(stim_word(1'b0));
    drain();

    // Directed: pinhole camera, corners, edges and rejections.
    load_matrix(pinhole(100));
    queue_word(pixel_word(0, 0));
    queue_word(pixel_word(ImageHeight - 1, ImageWidth - 1));
    queue_word(pixel_word(ImageHeight, 0));            // row beyond image: drop
    queue_word(pixel_word(0, ImageWidth));             // column beyond image: drop
    queue_word(pixel_word(511, 1023));
    queue_word(point_word(32'h0001_0000, 32'h0, 32'h0));                  // centre
    queue_word(point_word(32'h0001_0000, -32'sd210044, 32'h0));           // col -0.5 -> 0
    queue_word(point_word(32'h0001_0000, -32'sd220000, 32'h0));           // col below 0
    queue_word(point_word(32'h0001_0000, 32'sd210000, 32'h0));            // col at 640+
    queue_word(point_word(32'h0001_0000, 32'h0, 32'sd157286));            // row 479.x
    queue_word(point_word(32'h0001_0000, 32'h0, -32'sd157286));           // row just above 0
    queue_word(point_word(32'h0, 32'h0, 32'h0));                          // zero depth
    queue_word(point_word(-32'sd65536, 32'h0, 32'h0));                    // behind sensor
    queue_word(point_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    queue_word(point_word(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    queue_word(point_word(32'h8000_0000, 32'h0, 32'h0));
    queue_word(point_word(32'h0000_0001, 32'h0, 32'h0));
    drain();

    // Random phases: matrices and sender idling vary, extremes included.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: m = pinhole(100);
        1: m = pinhole(300);
        2: m = {6{64'hffff_ffff_ffff_ffff}};
        3: m = {6{64'h8000_0000_8000_0000}};
        4: m = {6{64'h7fff_ffff_7fff_ffff}};
        5: m = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        default: m = pinhole(50);
      endcase
      load_matrix(m);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 46;
        default: idle_pct = 12;
      endcase
      for (int i = 0; i < ((ph >= 2 && ph <= 5) ? 50 : 130); i++)
        queue_word(stim_word(ph >= 2 && ph <= 5 && $urandom_range(1)));
      drain();
    end

    if (mismatches == 0 && kept_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/lpc_pkg.sv
rtl/lpc_project.sv
rtl/lpc_divide.sv
rtl/lpc_frame.sv
rtl/lidar_point_colorizer_unit.sv
rtl/lpc_checker.sv
sim/lidar_point_colorizer_unit_tb.sv
